>>> hw/rtl/blr_pkg.sv
// Shared types and constants for the line rasteriser: coordinate width,
// the classified line command, the queue depth and the back-end states.
// No dependencies.
`timescale 1ns / 1ps

package blr_pkg;

  // Width of every coordinate field.
  localparam int unsigned COORD_BITS = 6;

  // Doubled-error accumulator: it stays within (-2*major, 3*major], which
  // needs two magnitude bits above the coordinate plus a sign bit.
  localparam int unsigned ACC_BITS = COORD_BITS + 3;

  // Depth of the command queue between front and back end.
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;

  // One line command after classification.
  typedef struct packed {
    coord_t x0;       // start point
    coord_t y0;
    coord_t major;    // |delta| along the stepping axis
    coord_t minor;    // |delta| along the other axis
    logic   along_x;  // x is the major axis
    logic   x_neg;    // x steps downwards
    logic   y_neg;    // y steps downwards
  } line_cmd_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

endpackage

>>> hw/rtl/bresenham_line_rasterizer.sv
// Top level of the line rasteriser: front end, command queue and back end.
// Depends on blr_pkg, blr_front, blr_cmd_queue and blr_back.
`timescale 1ns / 1ps

// A line request is taken when start is high and busy is low. The block
// answers with max(|dx|,|dy|)+1 pixels, one per clock cycle, each shown for
// exactly one cycle with pixel_strobe_o high; the start point comes first and
// last_pixel_o marks the end point. With the back end idle, the request is
// first written into the command queue; the back end then loads it from the
// queue into its registers and enters its run state, where the first pixel
// is shown. The stepping unit in the back end sets the rate, and a queued
// line follows the last pixel of the one before with no gap. A two-entry
// command queue sits in front of it, so busy rises only when two requests
// wait behind the line being drawn. The receiver cannot stall the pixel stream.
module bresenham_line_rasterizer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  blr_pkg::coord_t x_start_i,
  input  blr_pkg::coord_t y_start_i,
  input  blr_pkg::coord_t x_end_i,
  input  blr_pkg::coord_t y_end_i,
  output logic            pixel_strobe_o,
  output blr_pkg::coord_t pixel_x_o,
  output blr_pkg::coord_t pixel_y_o,
  output logic            last_pixel_o
);
  import blr_pkg::*;

  line_cmd_t     front_cmd;
  line_cmd_t     head_cmd;
  queue_status_t queue_status;
  logic          pop;

  // A request is refused only while the queue is full.
  assign busy = queue_status.full;

  blr_front u_front (
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .cmd_o     (front_cmd)
  );

  blr_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (start),
    .push_cmd_i (front_cmd),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .status_o   (queue_status)
  );

  blr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_cmd_i     (head_cmd),
    .queue_status_i (queue_status),
    .pop_o          (pop),
    .pixel_strobe_o (pixel_strobe_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

>>> hw/rtl/blr_front.sv
// Front end of the line rasteriser: classifies an accepted request into
// absolute deltas, step directions and major axis. Depends on blr_pkg.
`timescale 1ns / 1ps

module blr_front (
  input  blr_pkg::coord_t    x_start_i,
  input  blr_pkg::coord_t    y_start_i,
  input  blr_pkg::coord_t    x_end_i,
  input  blr_pkg::coord_t    y_end_i,
  output blr_pkg::line_cmd_t cmd_o
);
  import blr_pkg::*;

  logic   x_neg;
  logic   y_neg;
  coord_t dx_abs;
  coord_t dy_abs;
  logic   along_x;

  // Absolute deltas and the direction of each axis.
  always_comb begin
    x_neg  = (x_end_i < x_start_i);
    y_neg  = (y_end_i < y_start_i);
    dx_abs = x_neg ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
    dy_abs = y_neg ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
  end

  // Ties between the deltas step along x.
  assign along_x = (dy_abs <= dx_abs);

  // Pack the classified command for the queue.
  always_comb begin
    cmd_o.x0      = x_start_i;
    cmd_o.y0      = y_start_i;
    cmd_o.major   = along_x ? dx_abs : dy_abs;
    cmd_o.minor   = along_x ? dy_abs : dx_abs;
    cmd_o.along_x = along_x;
    cmd_o.x_neg   = x_neg;
    cmd_o.y_neg   = y_neg;
  end

endmodule

>>> hw/rtl/blr_cmd_queue.sv
// Short first-in first-out queue of classified line commands between the
// front and back ends of the rasteriser. Depends on blr_pkg.
`timescale 1ns / 1ps

module blr_cmd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  blr_pkg::line_cmd_t     push_cmd_i,
  input  logic                   pop_i,
  output blr_pkg::line_cmd_t     head_cmd_o,
  output blr_pkg::queue_status_t status_o
);
  import blr_pkg::*;

  line_cmd_t                 entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_BITS-1:0] count_q, count_d;
  logic                      do_push;
  logic                      do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_cmd_o     = entry_q[rd_ptr_q];

  // Pointer and fill count updates, with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTHESIS
  // The fill count never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  // An empty queue has its read and write pointers level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

>>> hw/rtl/blr_back.sv
// Back end of the line rasteriser: takes classified commands from the queue and
// steps the Bresenham error term, one pixel per cycle within a line. Depends on blr_pkg.
`timescale 1ns / 1ps

module blr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  blr_pkg::line_cmd_t     head_cmd_i,
  input  blr_pkg::queue_status_t queue_status_i,
  output logic                   pop_o,
  output logic                   pixel_strobe_o,
  output blr_pkg::coord_t        pixel_x_o,
  output blr_pkg::coord_t        pixel_y_o,
  output logic                   last_pixel_o
);
  import blr_pkg::*;

  bk_state_e                   state_q, state_d;
  line_cmd_t                   cmd_q;
  coord_t                      cx_q, cx_d;
  coord_t                      cy_q, cy_d;
  coord_t                      rem_q, rem_d;
  logic signed [ACC_BITS-1:0]  acc_q, acc_d;
  logic signed [ACC_BITS-1:0]  acc_sum;
  logic signed [ACC_BITS-1:0]  minor2;
  logic signed [ACC_BITS-1:0]  major1;
  logic signed [ACC_BITS-1:0]  major2;
  logic                        step_minor;
  logic                        line_done;
  logic                        load;
  coord_t                      cx_step;
  coord_t                      cy_step;

  assign line_done = (rem_q == '0);
  assign load      = pop_o;

  // Next state: a new line is taken straight after the last pixel of the one before.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!queue_status_i.empty) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (line_done && queue_status_i.empty) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    pop_o          = 1'b0;
    pixel_strobe_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        pop_o = !queue_status_i.empty;
      end
      BK_RUN: begin
        pixel_strobe_o = 1'b1;
        pop_o          = line_done && !queue_status_i.empty;
      end
      default: begin
        pop_o          = 1'b0;
        pixel_strobe_o = 1'b0;
      end
    endcase
  end

  assign pixel_x_o    = cx_q;
  assign pixel_y_o    = cy_q;
  assign last_pixel_o = pixel_strobe_o && line_done;

  // Error term: add twice the minor delta, step the minor axis when past the major delta.
  always_comb begin
    minor2     = signed'({2'b00, cmd_q.minor, 1'b0});
    major1     = signed'({3'b000, cmd_q.major});
    major2     = signed'({2'b00, cmd_q.major, 1'b0});
    acc_sum    = acc_q + minor2;
    step_minor = (acc_sum > major1);
    cx_step    = cmd_q.x_neg ? (cx_q - COORD_BITS'(1)) : (cx_q + COORD_BITS'(1));
    cy_step    = cmd_q.y_neg ? (cy_q - COORD_BITS'(1)) : (cy_q + COORD_BITS'(1));
  end

  // Coordinate, error and remaining-pixel updates.
  always_comb begin
    cx_d  = cx_q;
    cy_d  = cy_q;
    rem_d = rem_q;
    acc_d = acc_q;
    if (load) begin
      cx_d  = head_cmd_i.x0;
      cy_d  = head_cmd_i.y0;
      rem_d = head_cmd_i.major;
      acc_d = '0;
    end else if ((state_q == BK_RUN) && !line_done) begin
      rem_d = rem_q - COORD_BITS'(1);
      acc_d = step_minor ? (acc_sum - major2) : acc_sum;
      if (cmd_q.along_x) begin
        cx_d = cx_step;
        if (step_minor) begin
          cy_d = cy_step;
        end
      end else begin
        cy_d = cy_step;
        if (step_minor) begin
          cx_d = cx_step;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= head_cmd_i;
    end
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

`ifndef SYNTHESIS
  // A line that is not finished keeps the strobe up in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN && !line_done) |=> (state_q == BK_RUN))
    else $error("line stopped before its last pixel");

  // Every step moves the pixel along at least the major axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN && !line_done) |=>
      ((cx_q != $past(cx_q)) || (cy_q != $past(cy_q))))
    else $error("pixel repeated within a line");

  // A command is only taken from the queue between lines.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!queue_status_i.empty && (state_q == BK_IDLE || line_done)))
    else $error("command taken during a line");

  // The error term stays at or below the major delta while a line runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN) |-> (acc_q <= major1))
    else $error("error term out of range");
`endif

endmodule

>>> bench/bresenham_line_rasterizer_tb.sv
// Self-checking testbench for the line rasteriser: drives line requests and
// checks every pixel against a behavioural Bresenham predictor.
// Depends on blr_pkg and bresenham_line_rasterizer.
`timescale 1ns / 1ps

module bresenham_line_rasterizer_tb;

  import blr_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  coord_t x_start_i;
  coord_t y_start_i;
  coord_t x_end_i;
  coord_t y_end_i;
  logic   pixel_strobe_o;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;

  // Pixels still owed by the block, oldest first.
  pixel_t pending_pixels_q[$];

  int unsigned lines_sent;
  int unsigned pixels_checked;
  int unsigned pixel_mismatches;
  int unsigned stray_pixels;
  int unsigned quiet_cycles;

  bresenham_line_rasterizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .pixel_strobe_o(pixel_strobe_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .last_pixel_o  (last_pixel_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Walk the line the Bresenham way and queue every pixel it should produce.
  function automatic void predict_line_pixels(input coord_t x0, input coord_t y0,
                                              input coord_t x1, input coord_t y1);
    int     dx;
    int     dy;
    int     step_x;
    int     step_y;
    int     cur_x;
    int     cur_y;
    int     major_len;
    int     minor_len;
    int     err;
    bit     x_major;
    pixel_t pix;
    dx     = int'(x1) - int'(x0);
    dy     = int'(y1) - int'(y0);
    step_x = (dx < 0) ? -1 : 1;
    step_y = (dy < 0) ? -1 : 1;
    dx     = (dx < 0) ? -dx : dx;
    dy     = (dy < 0) ? -dy : dy;
    x_major   = (dy <= dx);
    major_len = x_major ? dx : dy;
    minor_len = x_major ? dy : dx;
    cur_x = int'(x0);
    cur_y = int'(y0);
    err   = 0;
    pix.x    = coord_t'(cur_x);
    pix.y    = coord_t'(cur_y);
    pix.last = (major_len == 0);
    pending_pixels_q.push_back(pix);
    for (int k = 1; k <= major_len; k++) begin
      err += 2 * minor_len;
      // A tie with the major delta leaves the minor axis where it is.
      if (x_major) begin
        cur_x += step_x;
        if (err > major_len) begin
          cur_y += step_y;
          err   -= 2 * major_len;
        end
      end else begin
        cur_y += step_y;
        if (err > major_len) begin
          cur_x += step_x;
          err   -= 2 * major_len;
        end
      end
      pix.x    = coord_t'(cur_x);
      pix.y    = coord_t'(cur_y);
      pix.last = (k == major_len);
      pending_pixels_q.push_back(pix);
    end
  endfunction

  // Present one line request and hold it until the block takes it. The
  // request line stays high afterwards; the next call or a pause decides.
  task automatic send_line(input int x0, input int y0, input int x1, input int y1);
    @(negedge clk_i);
    start     <= 1'b1;
    x_start_i <= coord_t'(x0);
    y_start_i <= coord_t'(y0);
    x_end_i   <= coord_t'(x1);
    y_end_i   <= coord_t'(y1);
    do @(posedge clk_i); while (busy);
    predict_line_pixels(coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1));
    lines_sent++;
  endtask

  // Drop the request line for a number of cycles.
  task automatic pause_requests(input int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Now and then insert an idle burst on the request side.
  task automatic maybe_pause(input bit allowed);
    if (allowed && ($urandom_range(0, 3) == 0)) begin
      pause_requests($urandom_range(1, 19));
    end
  endtask

  // Single pixels, full-length axis lines, the four diagonals and one line
  // in each octant, with random idle bursts between some of them.
  task automatic test_directed_lines();
    send_line(0, 0, 0, 0);
    send_line(63, 63, 63, 63);
    maybe_pause(1'b1);
    send_line(0, 63, 0, 63);
    send_line(0, 5, 63, 5);
    send_line(63, 40, 0, 40);
    maybe_pause(1'b1);
    send_line(7, 0, 7, 63);
    send_line(50, 63, 50, 0);
    send_line(0, 0, 63, 63);
    send_line(63, 63, 0, 0);
    maybe_pause(1'b1);
    send_line(0, 63, 63, 0);
    send_line(63, 0, 0, 63);
    send_line(10, 20, 30, 25);
    send_line(30, 25, 10, 20);
    send_line(10, 25, 30, 20);
    send_line(30, 20, 10, 25);
    maybe_pause(1'b1);
    send_line(20, 10, 25, 30);
    send_line(25, 30, 20, 10);
    send_line(20, 30, 25, 10);
    send_line(25, 10, 20, 30);
  endtask

  // Lines whose error term lands exactly on the major delta.
  task automatic test_error_ties();
    send_line(0, 0, 2, 1);
    send_line(10, 10, 14, 12);
    maybe_pause(1'b1);
    send_line(0, 0, 1, 2);
    send_line(40, 40, 38, 44);
  endtask

  // Random lines: a mix of arbitrary endpoints, short lines and axis-aligned
  // or diagonal lines. Idling is switched on and off in stretches.
  task automatic test_random_lines(input int unsigned count, input bit with_idle);
    int x0;
    int y0;
    int x1;
    int y1;
    int span;
    bit idle_on;
    idle_on = with_idle;
    for (int unsigned i = 0; i < count; i++) begin
      if (with_idle && (i % 25 == 0)) begin
        idle_on = $urandom_range(0, 2) != 0;
      end
      x0 = $urandom_range(0, 63);
      y0 = $urandom_range(0, 63);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          x1 = $urandom_range(0, 63);
          y1 = $urandom_range(0, 63);
        end
        5, 6, 7: begin
          x1 = $urandom_range((x0 > 8) ? x0 - 8 : 0, (x0 < 55) ? x0 + 8 : 63);
          y1 = $urandom_range((y0 > 8) ? y0 - 8 : 0, (y0 < 55) ? y0 + 8 : 63);
        end
        8: begin
          x1 = $urandom_range(0, 1) ? x0 : $urandom_range(0, 63);
          y1 = (x1 == x0) ? $urandom_range(0, 63) : y0;
        end
        default: begin
          span = $urandom_range(0, 63);
          x1 = $urandom_range(0, 1) ? x0 + span : x0 - span;
          y1 = $urandom_range(0, 1) ? y0 + span : y0 - span;
          if (x1 < 0 || x1 > 63 || y1 < 0 || y1 > 63) begin
            x1 = x0;
            y1 = y0;
          end
        end
      endcase
      send_line(x0, y0, x1, y1);
      maybe_pause(idle_on);
    end
  endtask

  // Pixel checker, sampled at the rising edge.
  always @(posedge clk_i) begin
    pixel_t exp_pix;
    if (rst_ni && pixel_strobe_o) begin
      if (pending_pixels_q.size() == 0) begin
        stray_pixels++;
        if (stray_pixels + pixel_mismatches <= REPORT_LIMIT) begin
          $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime,
                   pixel_x_o, pixel_y_o, last_pixel_o);
        end
      end else begin
        exp_pix = pending_pixels_q.pop_front();
        pixels_checked++;
        if (pixel_x_o !== exp_pix.x || pixel_y_o !== exp_pix.y ||
            last_pixel_o !== exp_pix.last) begin
          pixel_mismatches++;
          if (stray_pixels + pixel_mismatches <= REPORT_LIMIT) begin
            $display("%0t: pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $realtime, exp_pix.x, exp_pix.y, exp_pix.last,
                     pixel_x_o, pixel_y_o, last_pixel_o);
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which neither a request nor a pixel moves.
  always @(posedge clk_i) begin
    if ((start && !busy) || pixel_strobe_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    x_start_i        = '0;
    y_start_i        = '0;
    x_end_i          = '0;
    y_end_i          = '0;
    lines_sent       = 0;
    pixels_checked   = 0;
    pixel_mismatches = 0;
    stray_pixels     = 0;
    quiet_cycles     = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_lines();
    test_error_ties();
    test_random_lines(200, 1'b1);
    // Final stretch with the request line held high throughout.
    test_random_lines(60, 1'b0);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_pixels_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Drew %0d lines and checked %0d pixels: extremes, octants, error ties,",
             lines_sent, pixels_checked);
    $display("random lines with idle bursts and back-to-back requests.");
    if (pixel_mismatches == 0 && stray_pixels == 0 && pending_pixels_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d unexpected pixels, %0d pixels missing",
               pixel_mismatches, stray_pixels, pending_pixels_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
